// ----- rtl/core/hem_pkg.sv -----
// ---------------------------------------------------------------------------
// hem_pkg
// Shared types, sizes and codes of the heavy-edge matching core.
// ---------------------------------------------------------------------------
package hem_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int MAX_EDGES    = 4096;

  // Fixed field widths of the item format.
  localparam int OP_W     = 2;
  localparam int OIDX_W   = 11;
  localparam int OFF_W    = 13;
  localparam int EIDX_W   = 12;
  localparam int NB_W     = 10;
  localparam int WT_W     = 32;
  localparam int VX_W     = 10;
  localparam int STAT_W   = 3;
  localparam int CNT_W    = 11;

  // Storage address widths.
  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int OAW = $clog2(MAX_VERTICES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

  localparam logic [CNT_W-1:0] VCOUNT_RESET = CNT_W'(1024);
  localparam logic [CNT_W-1:0] PAIRS_MAX    = '1;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_VERTEX_COUNT = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_OFFSET = 2'd1,
    OP_EDGE   = 2'd2,
    OP_VISIT  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 3'd0,
    ST_PAIR    = 3'd1,
    ST_ALREADY = 3'd2,
    ST_NONE    = 3'd3,
    ST_RANGE   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_LOOK0,
    S_LOOK1,
    S_LOOK2,
    S_SCAN,
    S_MARK_VV,
    S_MARK_PICK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [OIDX_W-1:0]        offset_index;
    logic [OFF_W-1:0]         offset_value;
    logic [EIDX_W-1:0]        edge_index;
    logic [NB_W-1:0]          edge_neighbor;
    logic signed [WT_W-1:0]   edge_weight;
    logic [VX_W-1:0]          visit_vertex;
  } hem_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VX_W-1:0]   matched_vertex;
    logic [VX_W-1:0]   partner_vertex;
    logic [CNT_W-1:0]  pair_count;
  } hem_out_t;

  typedef struct packed {
    logic    accept;
    logic    clear_pairs;
    logic    sweep;
    logic    look_vv;
    logic    look_next;
    logic    take_end;
    logic    scan;
    logic    mark_vv;
    logic    mark_pick;
    logic    load_result;
    status_t res_status;
  } hem_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic vv_bad;
    logic vv_marked;
    logic scan_idle;
    logic found;
  } hem_stat_t;

endpackage

// ----- rtl/core/hem_dp.sv -----
// ---------------------------------------------------------------------------
// hem_dp
// Datapath: offset, edge and mark memories, the pipelined edge scan and
// the result register.
// ---------------------------------------------------------------------------
module hem_dp import hem_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  hem_cmd_t         cmd,
  output hem_stat_t        st,
  input  hem_in_t          in_data,
  input  logic [CNT_W-1:0] vertex_count,
  output hem_out_t         out_data
);

  typedef struct packed {
    logic [NB_W-1:0]        neighbor;
    logic signed [WT_W-1:0] weight;
  } edge_t;

  function automatic logic [OFF_W-1:0] clip_edge(input logic [OFF_W-1:0] x);
    clip_edge = (x > MAX_EDGES) ? OFF_W'(MAX_EDGES) : x;
  endfunction

  logic [OFF_W-1:0] offset_mem [MAX_VERTICES+1];
  edge_t            edge_mem   [MAX_EDGES];
  logic             mark_mem   [MAX_VERTICES];

  logic [OFF_W-1:0] offset_q;
  logic [OAW-1:0]   offset_raddr;
  logic             off_we;
  edge_t            edge_q;
  logic             edge_we;
  logic             mark_q;
  logic             mark_we;
  logic [VW-1:0]    mark_waddr;
  logic             mark_wdata;
  logic [VW-1:0]    mark_raddr;

  logic [VX_W-1:0]        vv;
  logic [OP_W-1:0]        op_q;
  logic [OFF_W-1:0]       j;
  logic [OFF_W-1:0]       end_ptr;
  logic                   issue;
  logic                   v0;
  logic                   v1;
  logic                   far0;
  logic signed [WT_W-1:0] w1;
  logic [VW-1:0]          to1;
  logic signed [WT_W-1:0] best;
  logic [VW-1:0]          pick;
  logic                   found;
  logic [CNT_W-1:0]       pairs;
  logic [VW-1:0]          sweep_cnt;
  logic [CNT_W-1:0]       limit;
  logic                   take;

  // The offset and edge write enables come straight from the accepted transaction.
  assign off_we  = cmd.accept && (in_data.op == OP_OFFSET)
                   && (in_data.offset_index <= MAX_VERTICES);
  assign edge_we = cmd.accept && (in_data.op == OP_EDGE)
                   && (in_data.edge_index < MAX_EDGES);

  assign offset_raddr = cmd.look_next ? (OAW'(vv) + OAW'(1)) : OAW'(vv);

  always_ff @(posedge clk) begin
    if (off_we) begin
      offset_mem[OAW'(in_data.offset_index)] <= in_data.offset_value;
    end
    offset_q <= offset_mem[offset_raddr];
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[EAW'(in_data.edge_index)] <= '{neighbor: in_data.edge_neighbor,
                                              weight:   in_data.edge_weight};
    end
    edge_q <= edge_mem[EAW'(j)];
  end

  always_comb begin
    mark_we    = 1'b0;
    mark_waddr = sweep_cnt;
    mark_wdata = 1'b0;
    if (cmd.sweep) begin
      mark_we = 1'b1;
    end else if (cmd.mark_vv) begin
      mark_we    = 1'b1;
      mark_waddr = VW'(vv);
      mark_wdata = 1'b1;
    end else if (cmd.mark_pick) begin
      mark_we    = 1'b1;
      mark_waddr = pick;
      mark_wdata = 1'b1;
    end
  end

  assign mark_raddr = cmd.look_vv ? VW'(vv) : VW'(edge_q.neighbor);

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    mark_q <= mark_mem[mark_raddr];
  end

  // Edge scan pipeline: issue an edge read, then read the neighbor's mark,
  // then compare. Strict greater-than keeps the first edge on ties.
  assign issue = cmd.scan && (j < end_ptr);
  assign far0  = (edge_q.neighbor >= MAX_VERTICES);
  assign take  = v1 && !mark_q && (w1 > best);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      v0 <= issue;
      v1 <= v0 && !far0;
    end
  end

  always_ff @(posedge clk) begin
    w1  <= edge_q.weight;
    to1 <= VW'(edge_q.neighbor);
    if (cmd.accept) begin
      vv   <= in_data.visit_vertex;
      op_q <= in_data.op;
    end
    if (cmd.look_next) begin
      j <= clip_edge(offset_q);
    end else if (issue) begin
      j <= j + OFF_W'(1);
    end
    if (cmd.take_end) begin
      end_ptr <= clip_edge(offset_q);
    end
    if (cmd.look_vv) begin
      best  <= '0;
      pick  <= '0;
      found <= 1'b0;
    end else if (take) begin
      best  <= w1;
      pick  <= to1;
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pairs     <= '0;
      sweep_cnt <= '0;
    end else begin
      if (cmd.clear_pairs) begin
        pairs <= '0;
      end else if (cmd.mark_pick && (pairs != PAIRS_MAX)) begin
        pairs <= pairs + CNT_W'(1);
      end
      if (cmd.sweep) begin
        sweep_cnt <= st.sweep_last ? '0 : sweep_cnt + VW'(1);
      end
    end
  end

  assign limit = (vertex_count > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : vertex_count;

  always_comb begin
    st.sweep_last = (sweep_cnt == VW'(MAX_VERTICES - 1));
    st.vv_bad     = (CNT_W'(vv) >= limit);
    st.vv_marked  = mark_q;
    st.scan_idle  = !(j < end_ptr) && !v0 && !v1;
    st.found      = found;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_data.status         <= cmd.res_status;
      out_data.matched_vertex <= (op_q == OP_VISIT) ? vv : '0;
      out_data.partner_vertex <= (cmd.res_status == ST_PAIR) ? VX_W'(pick) : '0;
      out_data.pair_count     <= pairs;
    end
  end

  assert property (@(posedge clk) disable iff (rst) cmd.scan |-> !mark_we)
    else $error("Mark memory written during an edge scan.");

  assert property (@(posedge clk) disable iff (rst)
                   (!cmd.clear_pairs && !cmd.mark_pick) |=> $stable(pairs))
    else $error("Pair count changed without a clear or a new pair.");

  assert property (@(posedge clk) disable iff (rst) v1 |-> $past(v0))
    else $error("Scan compare stage valid without a preceding edge read.");

endmodule

// ----- rtl/core/hem_ctrl.sv -----
// ---------------------------------------------------------------------------
// hem_ctrl
// Controller: sequences clear sweeps, table writes and vertex visits, and
// owns the input ready and the output valid.
// ---------------------------------------------------------------------------
module hem_ctrl import hem_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [OP_W-1:0] in_op,
  output logic            out_valid,
  input  logic            out_ready,
  output hem_cmd_t        cmd,
  input  hem_stat_t       st
);

  state_t  state;
  state_t  state_next;
  status_t code;
  status_t code_next;
  logic    accept;
  logic    load;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign load     = (state == S_RESP) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      code      <= ST_DONE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      code  <= code_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    code_next  = code;
    unique case (state)
      S_INIT: begin
        if (st.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_CLEAR:           state_next = S_CLEAR;
            OP_OFFSET, OP_EDGE: begin
              state_next = S_RESP;
              code_next  = ST_DONE;
            end
            OP_VISIT:           state_next = S_LOOK0;
            default:            state_next = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        if (st.sweep_last) begin
          state_next = S_RESP;
          code_next  = ST_DONE;
        end
      end
      S_LOOK0: begin
        if (st.vv_bad) begin
          state_next = S_RESP;
          code_next  = ST_RANGE;
        end else begin
          state_next = S_LOOK1;
        end
      end
      S_LOOK1: begin
        if (st.vv_marked) begin
          state_next = S_RESP;
          code_next  = ST_ALREADY;
        end else begin
          state_next = S_LOOK2;
        end
      end
      S_LOOK2: state_next = S_SCAN;
      S_SCAN: begin
        if (st.scan_idle) begin
          if (st.found) begin
            state_next = S_MARK_VV;
          end else begin
            state_next = S_RESP;
            code_next  = ST_NONE;
          end
        end
      end
      S_MARK_VV:   state_next = S_MARK_PICK;
      S_MARK_PICK: begin
        state_next = S_RESP;
        code_next  = ST_PAIR;
      end
      S_RESP: begin
        if (load) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.res_status  = code;
    cmd.accept      = accept;
    cmd.clear_pairs = accept && (in_op == OP_CLEAR);
    cmd.load_result = load;
    unique case (state)
      S_INIT, S_CLEAR: cmd.sweep     = 1'b1;
      S_LOOK0:         cmd.look_vv   = 1'b1;
      S_LOOK1:         cmd.look_next = 1'b1;
      S_LOOK2:         cmd.take_end  = 1'b1;
      S_SCAN:          cmd.scan      = 1'b1;
      S_MARK_VV:       cmd.mark_vv   = 1'b1;
      S_MARK_PICK:     cmd.mark_pick = 1'b1;
      default:         cmd.sweep     = 1'b0;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
                   (state == S_MARK_PICK) |-> ($past(state) == S_MARK_VV))
    else $error("Partner marked without marking the visited vertex first.");

  assert property (@(posedge clk) disable iff (rst)
                   (state == S_SCAN && st.scan_idle && st.found) |=> (state == S_MARK_VV))
    else $error("Finished scan with a candidate did not go on to marking.");

  assert property (@(posedge clk) disable iff (rst)
                   load |=> (out_valid && cmd.res_status == $past(code)))
    else $error("Result loaded without raising the output valid.");

endmodule

// ----- rtl/core/heavy_edge_matching_core.sv -----
// ---------------------------------------------------------------------------
// heavy_edge_matching_core
// Greedy heavy-edge matching over a compressed sparse row graph, with an
// APB register for the vertex count.
// ---------------------------------------------------------------------------
// An offset or edge write goes straight to its result; a clear first sweeps the full
// 1024-entry mark memory. A visit stops early when out of range or already matched,
// else reads its two offsets and scans the list (one edge read per cycle), marking
// both vertices when it finds a pair.
// After reset the same sweep runs with in_ready low. One transaction
// is in flight at a time; in_ready returns the cycle after its result loads.
module heavy_edge_matching_core import hem_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  hem_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hem_out_t          out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  hem_cmd_t         cmd;
  hem_stat_t        st;
  logic [CNT_W-1:0] vertex_count;
  logic             reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_VERTEX_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCOUNT_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      vertex_count <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = reg_hit ? APB_DW'(vertex_count) : '0;

  hem_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_data.op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .st        (st)
  );

  hem_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .in_data      (in_data),
    .vertex_count (vertex_count),
    .out_data     (out_data)
  );

endmodule

// ----- verif/heavy_edge_matching_core_tb.sv -----
// ---------------------------------------------------------------------------
// heavy_edge_matching_core_tb
// Self-checking bench for the heavy-edge matching core. Small graphs are
// loaded and matched under changing vertex counts and handshake pacing, and
// every result is compared with a behavioral mirror of the matcher.
// ---------------------------------------------------------------------------
module heavy_edge_matching_core_tb;
  import hem_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum {PACE_SLOW_RX, PACE_SLOW_TX, PACE_FULL} pace_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  hem_in_t           in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  hem_out_t          out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  heavy_edge_matching_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Mirror of the matcher state, advanced once per accepted transaction.
  logic [OFF_W-1:0]        mirror_off [0:MAX_VERTICES];
  logic [NB_W-1:0]         mirror_nbr [0:MAX_EDGES-1];
  logic signed [WT_W-1:0]  mirror_wt  [0:MAX_EDGES-1];
  bit [MAX_VERTICES-1:0]   mirror_marks = '0;
  logic [CNT_W-1:0]        mirror_pairs = '0;
  logic [CNT_W-1:0]        mirror_vcnt = VCOUNT_RESET;

  // What the stimulus builder knows has been written, so that no visit
  // ever reads an offset or edge entry that was never loaded.
  int gen_off [0:MAX_VERTICES];
  bit gen_off_ok [0:MAX_VERTICES];
  bit gen_edge_ok [0:MAX_EDGES-1];
  int gen_limit = MAX_VERTICES;

  hem_in_t  graph_items [$];
  hem_out_t awaited_q [$];

  pace_t idle_mode = PACE_SLOW_RX;
  bit    in_fire = 1'b0;
  bit    rx_hold = 1'b0;
  int    phase_no = 0;
  int    items_made = 0;
  int    clears_made = 0;
  int    settings_run = 0;
  int    n_checked = 0;
  int    errors = 0;
  int    status_seen [0:7];

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #8ms;
    $display("FAILURE");
    $finish;
  end

  function automatic int edge_clip(input int x);
    return (x > MAX_EDGES) ? MAX_EDGES : x;
  endfunction

  function automatic hem_out_t match_outcome(input hem_in_t it);
    hem_out_t res;
    int       limit;
    int       j;
    int       stop_at;
    int       pick;
    int       vv;
    longint   best;
    longint   w;
    bit       found;
    res = '0;
    vv = it.visit_vertex;
    case (op_t'(it.op))
      OP_CLEAR: begin
        mirror_marks = '0;
        mirror_pairs = '0;
      end
      OP_OFFSET: begin
        if (it.offset_index <= MAX_VERTICES) mirror_off[it.offset_index] = it.offset_value;
      end
      OP_EDGE: begin
        mirror_nbr[it.edge_index] = it.edge_neighbor;
        mirror_wt[it.edge_index] = it.edge_weight;
      end
      default: begin
        limit = (mirror_vcnt > MAX_VERTICES) ? MAX_VERTICES : int'(mirror_vcnt);
        res.matched_vertex = it.visit_vertex;
        if (vv >= limit) begin
          res.status = ST_RANGE;
        end else if (mirror_marks[vv]) begin
          res.status = ST_ALREADY;
        end else begin
          best = 0;
          found = 1'b0;
          pick = 0;
          stop_at = edge_clip(mirror_off[vv + 1]);
          // Strictly greater keeps the earliest edge among equal weights.
          for (j = edge_clip(mirror_off[vv]); j < stop_at; j++) begin
            w = mirror_wt[j];
            if (w > best && !mirror_marks[mirror_nbr[j]]) begin
              best = w;
              pick = mirror_nbr[j];
              found = 1'b1;
            end
          end
          if (found) begin
            mirror_marks[vv] = 1'b1;
            mirror_marks[pick] = 1'b1;
            if (mirror_pairs != PAIRS_MAX) mirror_pairs = mirror_pairs + 1'b1;
            res.status = ST_PAIR;
            res.partner_vertex = NB_W'(pick);
          end else begin
            res.status = ST_NONE;
          end
        end
      end
    endcase
    res.pair_count = mirror_pairs;
    return res;
  endfunction

  // ---- stimulus building ----

  function automatic hem_in_t rand_item(input op_t op);
    logic [95:0] r;
    hem_in_t     it;
    r = {$urandom(), $urandom(), $urandom()};
    it = r[$bits(hem_in_t)-1:0];
    it.op = op;
    return it;
  endfunction

  function automatic void queue_item(input hem_in_t it);
    case (op_t'(it.op))
      OP_CLEAR: clears_made++;
      OP_OFFSET: begin
        if (it.offset_index <= MAX_VERTICES) begin
          gen_off[it.offset_index] = it.offset_value;
          gen_off_ok[it.offset_index] = 1'b1;
        end
      end
      OP_EDGE: gen_edge_ok[it.edge_index] = 1'b1;
      default: ;
    endcase
    graph_items.insert(graph_items.size(), it);
    items_made++;
  endfunction

  function automatic bit visit_ok(input int v);
    int s;
    int e;
    int j;
    if (v >= gen_limit) return 1'b1;
    if (!gen_off_ok[v] || !gen_off_ok[v + 1]) return 1'b0;
    s = edge_clip(gen_off[v]);
    e = edge_clip(gen_off[v + 1]);
    // Long lists only slow the run down; keep them out.
    if (e - s > 48) return 1'b0;
    for (j = s; j < e; j++) begin
      if (!gen_edge_ok[j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void add_visit(input int v);
    hem_in_t it;
    if (visit_ok(v)) begin
      it = rand_item(OP_VISIT);
      it.visit_vertex = VX_W'(v);
      queue_item(it);
    end
  endfunction

  function automatic void put_offset(input int idx, input int val);
    hem_in_t it;
    it = rand_item(OP_OFFSET);
    it.offset_index = OIDX_W'(idx);
    it.offset_value = OFF_W'(val);
    queue_item(it);
  endfunction

  function automatic void put_edge(input int idx, input int nbr, input logic [31:0] w);
    hem_in_t it;
    it = rand_item(OP_EDGE);
    it.edge_index = EIDX_W'(idx);
    it.edge_neighbor = NB_W'(nbr);
    it.edge_weight = w;
    queue_item(it);
  endfunction

  function automatic void put_clear();
    queue_item(rand_item(OP_CLEAR));
  endfunction

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return -$urandom_range(1, 100);
      4, 5, 6: return $urandom_range(1, 6);
      default: return $urandom();
    endcase
  endfunction

  // Loads a small window of vertices with fresh edge lists, may queue a clear, then
  // visits each of them in shuffled order plus a few repeats and one random vertex.
  function automatic void add_graph_block();
    int b;
    int n;
    int e;
    int total;
    int run;
    int k;
    int j;
    int tmp;
    int nbr;
    int deg [10];
    int owner [64];
    int order [10];
    if (gen_limit < 2) begin
      b = $urandom_range(0, MAX_VERTICES - 1);
    end else if ($urandom_range(0, 4) == 0) begin
      b = gen_limit - $urandom_range(1, (gen_limit < 10) ? gen_limit : 10);
    end else begin
      b = $urandom_range(0, gen_limit - 1);
    end
    n = $urandom_range(1, 10);
    if (b + n > MAX_VERTICES) n = MAX_VERTICES - b;
    total = 0;
    for (k = 0; k < n; k++) begin
      deg[k] = $urandom_range(0, 5);
      total += deg[k];
    end
    if ($urandom_range(0, 7) == 0) e = MAX_EDGES - total;
    else e = $urandom_range(0, MAX_EDGES - total);
    run = e;
    for (k = 0; k <= n; k++) begin
      // An end offset past the edge store is clipped by the block.
      if (k == n && run == MAX_EDGES && $urandom_range(0, 1) == 1)
        put_offset(b + k, $urandom_range(MAX_EDGES, 8191));
      else
        put_offset(b + k, run);
      if (k < n) begin
        for (j = 0; j < deg[k]; j++) owner[run - e + j] = b + k;
        run += deg[k];
      end
    end
    for (j = 0; j < total; j++) begin
      case ($urandom_range(0, 9))
        0: nbr = $urandom_range(0, MAX_VERTICES - 1);
        1: nbr = owner[j];
        default: nbr = b + $urandom_range(0, n - 1);
      endcase
      put_edge(e + j, nbr, pick_weight());
    end
    if (clears_made < 30 && $urandom_range(0, 3) == 0) put_clear();
    for (k = 0; k < n; k++) order[k] = b + k;
    for (k = n - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (k = 0; k < n; k++) add_visit(order[k]);
    repeat ($urandom_range(0, 2)) add_visit(b + $urandom_range(0, n - 1));
    add_visit($urandom_range(0, MAX_VERTICES - 1));
  endfunction

  function automatic void add_noise();
    hem_in_t it;
    case ($urandom_range(0, 9))
      0: if (clears_made < 30) put_clear();
      1, 2: begin
        it = rand_item(OP_OFFSET);
        if ($urandom_range(0, 1) == 1)
          it.offset_index = OIDX_W'($urandom_range(MAX_VERTICES + 1, 2047));
        queue_item(it);
      end
      3, 4, 5: queue_item(rand_item(OP_EDGE));
      default: add_visit($urandom_range(0, MAX_VERTICES - 1));
    endcase
  endfunction

  // ---- configuration and sequencing ----

  task automatic write_vertex_count(input int vc);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'(4 * int'(REG_VERTEX_COUNT));
    pwdata <= {21'($urandom()), 11'(vc)};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    mirror_vcnt = 11'(vc);
    gen_limit = (vc > MAX_VERTICES) ? MAX_VERTICES : vc;
    settings_run++;
  endtask

  task automatic settle(input int extra);
    int n;
    n = 0;
    while ((graph_items.size() != 0 || in_valid || awaited_q.size() != 0) && n < 300000) begin
      @(posedge clk);
      n++;
    end
    repeat (extra) @(posedge clk);
  endtask

  task automatic run_phase(input int vc, input pace_t pace, input int target);
    int stop_at;
    settle(20);
    idle_mode = pace;
    write_vertex_count(vc);
    phase_no++;
    stop_at = items_made + target;
    while (items_made < stop_at) begin
      if ($urandom_range(0, 9) < 8) add_graph_block();
      else repeat ($urandom_range(1, 4)) add_noise();
    end
  endtask

  initial begin : sequencer
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    // The mark memory is swept after reset before the input opens.
    while (!in_ready) @(posedge clk);

    write_vertex_count(2047);
    put_offset(2047, 8191);
    put_offset(MAX_VERTICES + 1, 0);
    put_offset(1023, 4094);
    put_offset(1024, 8191);
    put_edge(4094, 1023, 5);
    put_edge(4095, 0, 5);
    add_visit(1023);
    add_visit(1023);
    put_offset(0, 0);
    put_offset(1, 4);
    put_offset(2, 4);
    put_offset(3, 2);
    put_edge(0, 1, 32'h8000_0000);
    put_edge(1, 2, 0);
    put_edge(2, 1023, 32'h7fff_ffff);
    put_edge(3, 1, 7);
    add_visit(0);
    add_visit(1);
    add_visit(2);
    settle(20);
    write_vertex_count(3);
    add_visit(3);
    add_visit(1023);
    add_visit(0);
    put_clear();
    // Vertex 1023 lies past the vertex count but is still a valid partner.
    add_visit(0);
    add_visit(1);
    add_visit(2);
    settle(20);
    write_vertex_count(0);
    add_visit(0);

    run_phase(MAX_VERTICES, PACE_SLOW_RX, 310);
    run_phase(1, PACE_SLOW_RX, 100);
    run_phase($urandom_range(2, MAX_VERTICES - 1), PACE_SLOW_TX, 310);
    run_phase(0, PACE_SLOW_TX, 100);
    run_phase(MAX_VERTICES, PACE_FULL, 310);
    run_phase($urandom_range(512, 2047), PACE_FULL, 300);
    settle(100);

    if (awaited_q.size() != 0) begin
      $display("%0d expected results never arrived", awaited_q.size());
      errors += awaited_q.size();
    end
    $display("Checked %0d transactions across %0d vertex-count settings, %0d clears.",
             n_checked, settings_run, clears_made);
    $display("Visits: %0d paired, %0d already matched, %0d without partner, %0d out of range.",
             status_seen[ST_PAIR], status_seen[ST_ALREADY], status_seen[ST_NONE],
             status_seen[ST_RANGE]);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Long receiver stall early in the first random phase so that the input
  // side backs up behind the held result.
  initial begin : long_stall
    wait (phase_no == 1);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (600) @(posedge clk);
    rx_hold = 1'b0;
  end

  // ---- driver, acceptance and monitor ----

  always @(posedge clk) begin : take_input
    in_fire = !rst && in_valid && in_ready;
    if (in_fire) awaited_q.insert(awaited_q.size(), match_outcome(in_data));
  end

  always @(negedge clk) begin : feed_input
    bit hold_back;
    case (idle_mode)
      PACE_SLOW_RX: hold_back = ($urandom_range(0, 99) < 6);
      PACE_SLOW_TX: hold_back = ($urandom_range(0, 99) < 65);
      default: hold_back = 1'b0;
    endcase
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (graph_items.size() != 0 && !hold_back) begin
        in_data <= graph_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drive_ready
    bit pause;
    case (idle_mode)
      PACE_SLOW_RX: pause = ($urandom_range(0, 99) < 65);
      PACE_SLOW_TX: pause = ($urandom_range(0, 99) < 6);
      default: pause = 1'b0;
    endcase
    out_ready <= !rx_hold && !pause;
  end

  task automatic note_bad(input string what, input logic [31:0] want, input logic [31:0] got);
    errors++;
    if (errors <= 10)
      $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin : check_output
    hem_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_q.size() == 0) begin
        note_bad("result with no transaction pending, status", 'x, out_data.status);
      end else begin
        want = awaited_q.pop_front();
        n_checked++;
        status_seen[want.status]++;
        if (out_data.status !== want.status)
          note_bad("status", want.status, out_data.status);
        if (out_data.matched_vertex !== want.matched_vertex)
          note_bad("matched_vertex", want.matched_vertex, out_data.matched_vertex);
        if (out_data.partner_vertex !== want.partner_vertex)
          note_bad("partner_vertex", want.partner_vertex, out_data.partner_vertex);
        if (out_data.pair_count !== want.pair_count)
          note_bad("pair_count", want.pair_count, out_data.pair_count);
      end
    end
  end

endmodule
